// File: rtl/core/raster_split_sequencer_defines.svh
// Assertion macros for the raster split sequencer RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef RASTER_SPLIT_SEQUENCER_DEFINES_SVH
`define RASTER_SPLIT_SEQUENCER_DEFINES_SVH

// Clock and reset given explicitly.
`define RSS_ASSERT_CLKRST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Default clock and reset names of this project.
`define RSS_ASSERT(label, prop, msg) `RSS_ASSERT_CLKRST(label, clk_i, rst_ni, prop, msg)

`endif

// File: rtl/core/rss_pkg.sv
// Package for the raster split sequencer: payload types, codes, control word
// layout and the microcode program. No dependencies.
`default_nettype none

package rss_pkg;

  localparam int DEF_TABLE_DEPTH = 8;

  localparam int CNT_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int PC_W       = 5;
  localparam int PROG_LEN   = 19;

  // Command codes of an input transaction
  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_VBLANK = 2'd1;
  localparam logic [1:0] CMD_LINE   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_BIAS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_PAL      = 2'd3;

  localparam logic [7:0] REG_WRITE_FLAG = 8'h80;
  localparam logic [7:0] REG_VSCROLL    = 8'd23;
  localparam logic [7:0] ARM_LINE_CMD   = 8'h93;  // write to register 19
  localparam logic [7:0] PAL_INDEX_CMD  = 8'h90;  // write to register 16

  localparam logic [7:0] RST_LINE_BIAS = 8'd2;
  localparam logic [7:0] RST_NO_REG    = 8'd255;
  localparam logic [7:0] RST_NO_PAL    = 8'd255;

  typedef struct packed {
    logic [1:0] command;
    logic [2:0] entry_index;
    logic [7:0] split_line;
    logic [7:0] first_reg;
    logic [7:0] first_value;
    logic [7:0] second_reg;
    logic [7:0] second_value;
    logic [7:0] palette_index;
    logic [2:0] pal_red;
    logic [2:0] pal_green;
    logic [2:0] pal_blue;
    logic [7:0] frame_vscroll;
  } in_item_t;

  typedef struct packed {
    logic       port_select;
    logic [7:0] port_byte;
    logic       last_write;
  } out_item_t;

  typedef struct packed {
    logic [7:0] line;
    logic [7:0] reg1;
    logic [7:0] val1;
    logic [7:0] reg2;
    logic [7:0] val2;
    logic [7:0] pidx;
    logic [2:0] red;
    logic [2:0] green;
    logic [2:0] blue;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Jump conditions: when true the step jumps and does nothing else
  typedef enum logic [2:0] {
    C_NONE, C_ALWAYS, C_CNT_ZERO, C_LINE_NZ, C_NO_PEND, C_NOT_A1, C_NOT_A2, C_NOT_AP
  } cond_e;

  typedef enum logic [2:0] {
    OP_NOP, OP_VB_INIT, OP_RD_CUR, OP_LD, OP_LD_FIX, OP_ADVANCE
  } op_e;

  typedef enum logic [3:0] {
    B_VAL1, B_REG1, B_VAL2, B_REG2, B_PIDX, B_PALCMD, B_RB, B_GREEN, B_ARM, B_ARMCMD
  } bsrc_e;

  // When the emitted byte is the final write of the transaction
  typedef enum logic [2:0] {
    L_NEVER, L_AFTER_R1, L_AFTER_R2, L_AFTER_PAL, L_ALWAYS
  } last_e;

  typedef enum logic [1:0] {
    E_NO, E_YES, E_IF_NO_ARM
  } end_e;

  typedef struct packed {
    cond_e           cond;
    logic [PC_W-1:0] target;
    op_e             op;
    logic            emit;
    bsrc_e           bsrc;
    logic            psel;
    last_e           last;
    end_e            fin;
  } ucw_t;

  typedef struct packed {
    logic  act;
    op_e   op;
    logic  emit;
    bsrc_e bsrc;
    logic  psel;
    last_e last;
  } ctrl_t;

  typedef struct packed {
    logic cnt_zero;
    logic line_nz;
    logic no_pend;
    logic not_a1;
    logic not_a2;
    logic not_ap;
    logic arm;
    logic can_emit;
  } status_t;

  // Program addresses
  localparam logic [PC_W-1:0] PC_V0  = 5'd0;
  localparam logic [PC_W-1:0] PC_V1  = 5'd1;
  localparam logic [PC_W-1:0] PC_V2  = 5'd2;
  localparam logic [PC_W-1:0] PC_A0  = 5'd3;
  localparam logic [PC_W-1:0] PC_A1  = 5'd4;
  localparam logic [PC_W-1:0] PC_A2  = 5'd5;
  localparam logic [PC_W-1:0] PC_A3  = 5'd6;
  localparam logic [PC_W-1:0] PC_A4  = 5'd7;
  localparam logic [PC_W-1:0] PC_A5  = 5'd8;
  localparam logic [PC_W-1:0] PC_A6  = 5'd9;
  localparam logic [PC_W-1:0] PC_A7  = 5'd10;
  localparam logic [PC_W-1:0] PC_A8  = 5'd11;
  localparam logic [PC_W-1:0] PC_A9  = 5'd12;
  localparam logic [PC_W-1:0] PC_R0  = 5'd13;
  localparam logic [PC_W-1:0] PC_R1  = 5'd14;
  localparam logic [PC_W-1:0] PC_L0  = 5'd15;
  localparam logic [PC_W-1:0] PC_L1  = 5'd16;
  localparam logic [PC_W-1:0] PC_L2  = 5'd17;
  localparam logic [PC_W-1:0] PC_END = 5'd18;

  function automatic ucw_t uw(cond_e c, logic [PC_W-1:0] t, op_e o, logic e,
                              bsrc_e b, logic s, last_e l, end_e n);
    ucw_t w;
    w.cond   = c;
    w.target = t;
    w.op     = o;
    w.emit   = e;
    w.bsrc   = b;
    w.psel   = s;
    w.last   = l;
    w.fin    = n;
    return w;
  endfunction

  function automatic ucw_t rss_rom(logic [PC_W-1:0] pc);
    ucw_t w;
    case (pc)
      // vblank: load scroll, fetch split 0, fix its scroll value
      PC_V0:  w = uw(C_NONE,     PC_V0,  OP_VB_INIT, 1'b0, B_VAL1,   1'b0, L_NEVER, E_NO);
      PC_V1:  w = uw(C_CNT_ZERO, PC_END, OP_LD_FIX,  1'b0, B_VAL1,   1'b0, L_NEVER, E_NO);
      PC_V2:  w = uw(C_LINE_NZ,  PC_R0,  OP_NOP,     1'b0, B_VAL1,   1'b0, L_NEVER, E_NO);
      // apply the split held in the entry register, then fetch the next split to arm
      PC_A0:  w = uw(C_NOT_A1,   PC_A2,  OP_NOP,     1'b1, B_VAL1,   1'b0, L_NEVER, E_NO);
      PC_A1:  w = uw(C_NONE,     PC_A1,  OP_NOP,     1'b1, B_REG1,   1'b0, L_AFTER_R1, E_NO);
      PC_A2:  w = uw(C_NOT_A2,   PC_A4,  OP_NOP,     1'b1, B_VAL2,   1'b0, L_NEVER, E_NO);
      PC_A3:  w = uw(C_NONE,     PC_A3,  OP_NOP,     1'b1, B_REG2,   1'b0, L_AFTER_R2, E_NO);
      PC_A4:  w = uw(C_NOT_AP,   PC_A8,  OP_NOP,     1'b1, B_PIDX,   1'b0, L_NEVER, E_NO);
      PC_A5:  w = uw(C_NONE,     PC_A5,  OP_NOP,     1'b1, B_PALCMD, 1'b0, L_NEVER, E_NO);
      PC_A6:  w = uw(C_NONE,     PC_A6,  OP_NOP,     1'b1, B_RB,     1'b1, L_NEVER, E_NO);
      PC_A7:  w = uw(C_NONE,     PC_A7,  OP_NOP,     1'b1, B_GREEN,  1'b1, L_AFTER_PAL, E_NO);
      PC_A8:  w = uw(C_NONE,     PC_A8,  OP_ADVANCE, 1'b0, B_VAL1,   1'b0, L_NEVER, E_IF_NO_ARM);
      PC_A9:  w = uw(C_NONE,     PC_A9,  OP_LD,      1'b0, B_VAL1,   1'b0, L_NEVER, E_NO);
      // program register 19 for the split in the entry register
      PC_R0:  w = uw(C_NONE,     PC_R0,  OP_NOP,     1'b1, B_ARM,    1'b0, L_NEVER, E_NO);
      PC_R1:  w = uw(C_NONE,     PC_R1,  OP_NOP,     1'b1, B_ARMCMD, 1'b0, L_ALWAYS, E_YES);
      // line interrupt: fetch the pending split
      PC_L0:  w = uw(C_NO_PEND,  PC_END, OP_RD_CUR,  1'b0, B_VAL1,   1'b0, L_NEVER, E_NO);
      PC_L1:  w = uw(C_NONE,     PC_L1,  OP_LD,      1'b0, B_VAL1,   1'b0, L_NEVER, E_NO);
      PC_L2:  w = uw(C_ALWAYS,   PC_A0,  OP_NOP,     1'b0, B_VAL1,   1'b0, L_NEVER, E_NO);
      PC_END: w = uw(C_NONE,     PC_END, OP_NOP,     1'b0, B_VAL1,   1'b0, L_NEVER, E_YES);
      default: w = uw(C_NONE,    PC_END, OP_NOP,     1'b0, B_VAL1,   1'b0, L_NEVER, E_YES);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/raster_split_sequencer.sv
// Top level of the raster split sequencer: input dispatch, microcode
// sequencer and datapath. Depends on rss_pkg, rss_seq and rss_datapath.
//
//  channel | signals                          | direction | payload
//  --------+----------------------------------+-----------+---------------------
//  input   | in_valid_i / in_ready_o          | in        | in_item_i (in_item_t)
//  output  | out_valid_o / out_ready_i        | out       | out_item_o (out_item_t)
//  config  | cfg_we_i, cfg_idx_i, cfg_data_i  | in        | 8-bit register data
//
// Table writes and ignored commands do not make the block busy. A vblank or line
// interrupt runs the microcode program, with one port write per step at most;
// the next transaction is taken once the program ends, and a step that emits
// waits while the output register is stalled.
// in_ready_o is low while the program runs; the output register frees the
// block to take the next transaction while the last write still waits.
// Reset returns frame state and configuration to their reset values; table contents are unset.
`default_nettype none

module raster_split_sequencer #(
  parameter int TABLE_DEPTH = rss_pkg::DEF_TABLE_DEPTH
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire rss_pkg::in_item_t              in_item_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output rss_pkg::out_item_t                  out_item_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [rss_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [rss_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import rss_pkg::*;

  logic            busy, in_accept, start;
  logic [PC_W-1:0] start_pc;
  ctrl_t           ctrl;
  status_t         status;

  assign in_ready_o = !busy;
  assign in_accept  = in_valid_i && !busy;
  assign start      = in_accept &&
                      (in_item_i.command == CMD_VBLANK || in_item_i.command == CMD_LINE);
  assign start_pc   = (in_item_i.command == CMD_VBLANK) ? PC_V0 : PC_L0;

  rss_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .start_pc_i (start_pc),
    .status_i   (status),
    .ctrl_o     (ctrl),
    .busy_o     (busy)
  );

  rss_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_accept_i (in_accept),
    .in_item_i   (in_item_i),
    .ctrl_i      (ctrl),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// File: rtl/core/rss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/rss_seq.sv
// Microcode sequencer: step counter, program ROM lookup and jump logic.
// Depends on rss_pkg.
`default_nettype none

module rss_seq (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [rss_pkg::PC_W-1:0] start_pc_i,
  input  wire rss_pkg::status_t         status_i,
  output rss_pkg::ctrl_t                ctrl_o,
  output logic                          busy_o
);
  import rss_pkg::*;

  logic            busy_q, busy_d;
  logic [PC_W-1:0] pc_q, pc_d;
  ucw_t            cw;
  logic            cond_hit;

  function automatic logic cond_eval(cond_e c, status_t s);
    logic r;
    case (c)
      C_NONE:     r = 1'b0;
      C_ALWAYS:   r = 1'b1;
      C_CNT_ZERO: r = s.cnt_zero;
      C_LINE_NZ:  r = s.line_nz;
      C_NO_PEND:  r = s.no_pend;
      C_NOT_A1:   r = s.not_a1;
      C_NOT_A2:   r = s.not_a2;
      C_NOT_AP:   r = s.not_ap;
      default:    r = 1'b0;
    endcase
    return r;
  endfunction

  always_comb begin
    cw          = rss_rom(pc_q);
    cond_hit    = cond_eval(cw.cond, status_i);
    busy_d      = busy_q;
    pc_d        = pc_q;
    ctrl_o.act  = 1'b0;
    ctrl_o.op   = cw.op;
    ctrl_o.emit = cw.emit;
    ctrl_o.bsrc = cw.bsrc;
    ctrl_o.psel = cw.psel;
    ctrl_o.last = cw.last;
    if (busy_q) begin
      if (cond_hit) begin
        pc_d = cw.target;
      end else if (!cw.emit || status_i.can_emit) begin
        ctrl_o.act = 1'b1;
        if (cw.fin == E_YES || (cw.fin == E_IF_NO_ARM && !status_i.arm)) begin
          busy_d = 1'b0;
        end else begin
          pc_d = pc_q + 1'b1;
        end
      end
    end else if (start_i) begin
      busy_d = 1'b1;
      pc_d   = start_pc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= PC_V0;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
    end
  end

  assign busy_o = busy_q;

endmodule

`default_nettype wire

// File: rtl/core/rss_datapath.sv
// Datapath: configuration, frame state, entry register, split table RAM and
// output register. Depends on rss_pkg, rss_ram and the assertion macros.
`default_nettype none
`include "raster_split_sequencer_defines.svh"

module rss_datapath #(
  parameter int TABLE_DEPTH = rss_pkg::DEF_TABLE_DEPTH
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [rss_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [rss_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                           in_accept_i,
  input  wire rss_pkg::in_item_t              in_item_i,
  input  wire rss_pkg::ctrl_t                 ctrl_i,
  output rss_pkg::status_t                    status_o,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output rss_pkg::out_item_t                  out_item_o
);
  import rss_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [CNT_W-1:0] count_q, ns_q;
  logic [7:0]       bias_q, noreg_q, nopal_q, tracked_q, vscroll_q;
  entry_t           ent_q;
  logic             out_valid_q;
  out_item_t        out_q;

  logic [CNT_W-1:0] cnt_new;
  logic [CNT_W:0]   ns_inc;
  logic             arm;
  logic             a1, a2, ap;
  logic [ENTRY_W-1:0] rdata;
  entry_t           rd_ent, fix_ent, new_ent;
  logic             tbl_wr, fix_wr, ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic             can_emit, last_bit;
  logic [7:0]       byte_sel;

  assign ns_inc = {1'b0, ns_q} + 1'b1;
  assign arm    = ns_inc < {1'b0, count_q};
  assign a1     = ent_q.reg1 != noreg_q;
  assign a2     = ent_q.reg2 != noreg_q;
  assign ap     = ent_q.pidx != nopal_q;
  assign can_emit = !out_valid_q || out_ready_i;

  assign status_o.cnt_zero = count_q == '0;
  assign status_o.line_nz  = ent_q.line != 8'd0;
  assign status_o.no_pend  = ns_q >= count_q;
  assign status_o.not_a1   = !a1;
  assign status_o.not_a2   = !a2;
  assign status_o.not_ap   = !ap;
  assign status_o.arm      = arm;
  assign status_o.can_emit = can_emit;

  // Split table
  assign rd_ent = entry_t'(rdata);

  always_comb begin
    fix_ent = rd_ent;
    if (rd_ent.reg2 == REG_VSCROLL) begin
      fix_ent.val2 = tracked_q;
    end
    new_ent.line  = in_item_i.split_line;
    new_ent.reg1  = in_item_i.first_reg;
    new_ent.val1  = in_item_i.first_value;
    new_ent.reg2  = in_item_i.second_reg;
    new_ent.val2  = in_item_i.second_value;
    new_ent.pidx  = in_item_i.palette_index;
    new_ent.red   = in_item_i.pal_red;
    new_ent.green = in_item_i.pal_green;
    new_ent.blue  = in_item_i.pal_blue;
  end

  assign tbl_wr = in_accept_i && in_item_i.command == CMD_WRITE &&
                  int'(in_item_i.entry_index) < TABLE_DEPTH;
  assign fix_wr = ctrl_i.act && ctrl_i.op == OP_LD_FIX && rd_ent.reg2 == REG_VSCROLL;
  assign ram_we    = tbl_wr || fix_wr;
  assign ram_waddr = tbl_wr ? AW'(in_item_i.entry_index) : '0;
  assign ram_wdata = tbl_wr ? new_ent : fix_ent;

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    if (ctrl_i.act) begin
      case (ctrl_i.op)
        OP_VB_INIT: ram_re = 1'b1;
        OP_RD_CUR: begin
          ram_re    = 1'b1;
          ram_raddr = AW'(ns_q);
        end
        OP_ADVANCE: begin
          ram_re    = 1'b1;
          ram_raddr = AW'(ns_inc);
        end
        default: ram_re = 1'b0;
      endcase
    end
  end

  rss_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  // Byte and last-write selection
  always_comb begin
    case (ctrl_i.bsrc)
      B_VAL1:   byte_sel = ent_q.val1;
      B_REG1:   byte_sel = REG_WRITE_FLAG | ent_q.reg1;
      B_VAL2:   byte_sel = ent_q.val2;
      B_REG2:   byte_sel = REG_WRITE_FLAG | ent_q.reg2;
      B_PIDX:   byte_sel = ent_q.pidx;
      B_PALCMD: byte_sel = PAL_INDEX_CMD;
      B_RB:     byte_sel = {1'b0, ent_q.red, 1'b0, ent_q.blue};
      B_GREEN:  byte_sel = {5'd0, ent_q.green};
      B_ARM:    byte_sel = ent_q.line + tracked_q - bias_q;
      B_ARMCMD: byte_sel = ARM_LINE_CMD;
      default:  byte_sel = 8'd0;
    endcase
    case (ctrl_i.last)
      L_NEVER:     last_bit = 1'b0;
      L_AFTER_R1:  last_bit = !a2 && !ap && !arm;
      L_AFTER_R2:  last_bit = !ap && !arm;
      L_AFTER_PAL: last_bit = !arm;
      L_ALWAYS:    last_bit = 1'b1;
      default:     last_bit = 1'b0;
    endcase
  end

  always_comb begin
    cnt_new = cfg_data_i[CNT_W-1:0];
    if (int'(cnt_new) > TABLE_DEPTH) begin
      cnt_new = CNT_W'(TABLE_DEPTH);
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ns_q        <= '0;
      bias_q      <= RST_LINE_BIAS;
      noreg_q     <= RST_NO_REG;
      nopal_q     <= RST_NO_PAL;
      tracked_q   <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SPLIT_COUNT: begin
            count_q <= cnt_new;
            if (cnt_new == '0) begin
              ns_q <= '0;
            end
          end
          CFG_LINE_BIAS: bias_q  <= cfg_data_i;
          CFG_NO_REG:    noreg_q <= cfg_data_i;
          CFG_NO_PAL:    nopal_q <= cfg_data_i;
          default:       bias_q  <= bias_q;
        endcase
      end
      if (ctrl_i.act && ctrl_i.op == OP_VB_INIT) begin
        ns_q      <= '0;
        tracked_q <= vscroll_q;
      end
      if (ctrl_i.act && ctrl_i.op == OP_ADVANCE) begin
        ns_q <= ns_inc[CNT_W-1:0];
        if (ent_q.reg2 == REG_VSCROLL) begin
          tracked_q <= ent_q.val2;
        end else if (ent_q.reg1 == REG_VSCROLL) begin
          tracked_q <= ent_q.val1;
        end
      end
      if (ctrl_i.act && ctrl_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept_i) begin
      vscroll_q <= in_item_i.frame_vscroll;
    end
    if (ctrl_i.act && ctrl_i.op == OP_LD) begin
      ent_q <= rd_ent;
    end else if (ctrl_i.act && ctrl_i.op == OP_LD_FIX) begin
      ent_q <= fix_ent;
    end
    if (ctrl_i.act && ctrl_i.emit) begin
      out_q.port_select <= ctrl_i.psel;
      out_q.port_byte   <= byte_sel;
      out_q.last_write  <= last_bit;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `RSS_ASSERT(a_emit_has_room, ctrl_i.act && ctrl_i.emit |-> can_emit, "emit into full output slot")
  `RSS_ASSERT(a_count_bound, int'(count_q) <= TABLE_DEPTH, "split count above table depth")
  `RSS_ASSERT(a_advance_pending, ctrl_i.act && ctrl_i.op == OP_ADVANCE |-> ns_q < count_q, "advance without pending split")

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for raster_split_sequencer: directed and random
// table writes, vblank and line interrupt transactions against a local predictor.
// Depends on rss_pkg and the raster_split_sequencer RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rss_pkg::*;

  localparam logic [1:0] CMD_IGNORED = 2'd3;
  localparam int unsigned LIMIT     = 400000;
  localparam int          SETTLE    = 40;
  localparam int          RAND_ITEMS = 90;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  in_item_t              in_item_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_item_t             out_item_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  raster_split_sequencer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predictor state: split table plus frame state and register copies
  in_item_t    split_tab [DEF_TABLE_DEPTH];
  logic [3:0]  m_count = 4'd0;
  logic [3:0]  m_next = 4'd0;
  logic [7:0]  m_scroll = 8'd0;
  logic [7:0]  m_bias = RST_LINE_BIAS;
  logic [7:0]  m_noreg = RST_NO_REG;
  logic [7:0]  m_nopal = RST_NO_PAL;

  in_item_t    pending_items [$];
  out_item_t   expected_writes [$];

  bit          no_idle = 1'b0;
  bit          long_stall_go = 1'b0;
  bit          long_stall_done = 1'b0;
  int          tx_gap = 0;
  int          rx_gap = 0;
  int          stall_cnt = 0;
  int unsigned cycles = 0;
  int          mismatches = 0;
  int          n_offered = 0;
  int          n_vblank = 0;
  int          n_line = 0;
  int          n_checked = 0;

  function automatic void push_write(logic sel, logic [7:0] byte_val);
    out_item_t w;
    w.port_select = sel;
    w.port_byte   = byte_val;
    w.last_write  = 1'b0;
    expected_writes.push_back(w);
  endfunction

  // Register 19 gets the split line shifted by scroll and bias, mod 256
  function automatic void arm_line(logic [2:0] idx);
    logic [7:0] v;
    v = split_tab[idx].split_line + m_scroll - m_bias;
    push_write(1'b0, v);
    push_write(1'b0, ARM_LINE_CMD);
  endfunction

  function automatic void apply_split();
    in_item_t s;
    s = split_tab[m_next[2:0]];
    if (s.first_reg != m_noreg) begin
      push_write(1'b0, s.first_value);
      push_write(1'b0, REG_WRITE_FLAG | s.first_reg);
    end
    if (s.second_reg != m_noreg) begin
      push_write(1'b0, s.second_value);
      push_write(1'b0, REG_WRITE_FLAG | s.second_reg);
    end
    if (s.palette_index != m_nopal) begin
      push_write(1'b0, s.palette_index);
      push_write(1'b0, PAL_INDEX_CMD);
      push_write(1'b1, {1'b0, s.pal_red, 1'b0, s.pal_blue});
      push_write(1'b1, {5'd0, s.pal_green});
    end
    // scroll tracking ignores the no-register code
    if (s.first_reg == REG_VSCROLL) m_scroll = s.first_value;
    if (s.second_reg == REG_VSCROLL) m_scroll = s.second_value;
    m_next = m_next + 4'd1;
    if (m_next < m_count) arm_line(m_next[2:0]);
  endfunction

  function automatic void predict_port_writes(in_item_t it);
    int        before_n;
    out_item_t w;
    before_n = expected_writes.size();
    case (it.command)
      CMD_WRITE: split_tab[it.entry_index] = it;
      CMD_VBLANK: begin
        m_next   = 4'd0;
        m_scroll = it.frame_vscroll;
        if (m_count != 4'd0) begin
          if (split_tab[0].second_reg == REG_VSCROLL) split_tab[0].second_value = m_scroll;
          if (split_tab[0].split_line == 8'd0) apply_split();
          else arm_line(3'd0);
        end
      end
      CMD_LINE: if (m_next < m_count) apply_split();
      default: ;
    endcase
    if (expected_writes.size() > before_n) begin
      w = expected_writes.pop_back();
      w.last_write = 1'b1;
      expected_writes.push_back(w);
    end
  endfunction

  always @(posedge clk_i) begin : item_driver
    logic offer;
    if (rst_ni) begin
      offer = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        predict_port_writes(in_item_i);
        offer  = 1'b0;
        tx_gap = no_idle ? 0 : $urandom_range(0, 9);
      end
      if (!offer) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pending_items.size() > 0) begin
          in_item_i <= pending_items.pop_front();
          offer = 1'b1;
        end
      end
      in_valid_i <= offer;
    end
  end

  always @(posedge clk_i) begin : port_monitor
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        n_checked++;
        if (expected_writes.size() == 0) begin
          $error("port write with none expected: sel %0d byte %02h last %0d",
                 out_item_o.port_select, out_item_o.port_byte, out_item_o.last_write);
          mismatches++;
        end else begin
          want = expected_writes.pop_front();
          if (out_item_o.port_select !== want.port_select) begin
            $error("port_select: expected %0d, got %0d", want.port_select, out_item_o.port_select);
            mismatches++;
          end
          if (out_item_o.port_byte !== want.port_byte) begin
            $error("port_byte: expected %02h, got %02h", want.port_byte, out_item_o.port_byte);
            mismatches++;
          end
          if (out_item_o.last_write !== want.last_write) begin
            $error("last_write: expected %0d, got %0d", want.last_write, out_item_o.last_write);
            mismatches++;
          end
        end
        rx_gap = no_idle ? 0 : $urandom_range(0, 9);
      end
      if (long_stall_go && !long_stall_done) begin
        stall_cnt       = 150;
        long_stall_done = 1'b1;
      end
      if (stall_cnt > 0) begin
        stall_cnt--;
        out_ready_i <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic queue_item(in_item_t it);
    pending_items.push_back(it);
    if (it.command != CMD_IGNORED) n_offered++;
    if (it.command == CMD_VBLANK) n_vblank++;
    if (it.command == CMD_LINE) n_line++;
  endtask

  function automatic in_item_t mk_event(logic [1:0] cmd, logic [7:0] scroll);
    logic [95:0] r;
    in_item_t    it;
    r  = {$urandom, $urandom, $urandom};
    it = r[$bits(in_item_t)-1:0];
    it.command       = cmd;
    it.frame_vscroll = scroll;
    return it;
  endfunction

  function automatic in_item_t mk_entry(logic [2:0] idx, logic [7:0] line,
                                        logic [7:0] r1, logic [7:0] v1,
                                        logic [7:0] r2, logic [7:0] v2,
                                        logic [7:0] pidx, logic [2:0] red,
                                        logic [2:0] green, logic [2:0] blue);
    in_item_t it;
    it = mk_event(CMD_WRITE, 8'($urandom));
    it.entry_index   = idx;
    it.split_line    = line;
    it.first_reg     = r1;
    it.first_value   = v1;
    it.second_reg    = r2;
    it.second_value  = v2;
    it.palette_index = pidx;
    it.pal_red       = red;
    it.pal_green     = green;
    it.pal_blue      = blue;
    return it;
  endfunction

  // Register slots lean toward the no-register code and the scroll register
  function automatic logic [7:0] pick_reg();
    case ($urandom_range(0, 5))
      0, 1:    return m_noreg;
      2:       return REG_VSCROLL;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic in_item_t rand_entry();
    logic [7:0] line;
    logic [7:0] pidx;
    line = ($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom);
    pidx = ($urandom_range(0, 2) == 0) ? m_nopal : 8'($urandom);
    return mk_entry(3'($urandom), line, pick_reg(), 8'($urandom), pick_reg(),
                    8'($urandom), pidx, 3'($urandom), 3'($urandom), 3'($urandom));
  endfunction

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_SPLIT_COUNT: begin
        m_count = (val[3:0] > DEF_TABLE_DEPTH) ? 4'(DEF_TABLE_DEPTH) : val[3:0];
        if (val[3:0] == 4'd0) m_next = 4'd0;
      end
      CFG_LINE_BIAS: m_bias  = val;
      CFG_NO_REG:    m_noreg = val;
      CFG_NO_PAL:    m_nopal = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Sample at the falling edge so the driver's updates have settled
  task automatic wait_idle();
    @(negedge clk_i);
    while (pending_items.size() != 0 || in_valid_i || expected_writes.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int base;
    int phases;
    int n_lines;
    int kind;
    logic [7:0] pick;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Fill every slot first so no split read ever hits an unwritten entry
    queue_item(mk_entry(3'd0, 8'd0, 8'd255, 8'h00, REG_VSCROLL, 8'h11, 8'd255, 3'd0, 3'd0, 3'd0));
    queue_item(mk_entry(3'd1, 8'd255, 8'd0, 8'hFF, 8'd254, 8'h00, 8'd0, 3'd7, 3'd0, 3'd7));
    queue_item(mk_entry(3'd2, 8'd1, REG_VSCROLL, 8'h40, 8'd255, 8'h99, 8'd255, 3'd1, 3'd6, 3'd1));
    queue_item(mk_entry(3'd3, 8'd128, 8'd7, 8'h5A, REG_VSCROLL, 8'hC3, 8'd254, 3'd0, 3'd7, 3'd0));
    queue_item(mk_entry(3'd4, 8'd100, 8'd255, 8'h12, 8'd255, 8'h34, 8'd255, 3'd3, 3'd3, 3'd3));
    queue_item(mk_entry(3'd5, 8'h55, 8'h7F, 8'hAA, 8'h80, 8'h55, 8'h0F, 3'd5, 3'd2, 3'd3));
    queue_item(mk_entry(3'd6, 8'hAA, 8'd16, 8'h3C, 8'd19, 8'hC3, 8'h80, 3'd2, 3'd5, 3'd4));
    queue_item(mk_entry(3'd7, 8'd250, 8'd1, 8'h81, 8'd2, 8'h7E, 8'hF0, 3'd7, 3'd7, 3'd7));
    // no splits in use: both events are silent, command 3 is dropped
    queue_item(mk_event(CMD_LINE, 8'h00));
    queue_item(mk_event(CMD_VBLANK, 8'h12));
    queue_item(mk_event(CMD_IGNORED, 8'h00));
    wait_idle();

    // split count above table depth saturates; zero bias
    set_reg(CFG_SPLIT_COUNT, 8'd15);
    set_reg(CFG_LINE_BIAS, 8'd0);
    queue_item(mk_event(CMD_VBLANK, 8'hAB));
    repeat (8) queue_item(mk_event(CMD_LINE, 8'h00));
    wait_idle();

    // scroll register as the no-register code still gets tracked
    set_reg(CFG_NO_REG, REG_VSCROLL);
    set_reg(CFG_LINE_BIAS, 8'd255);
    set_reg(CFG_NO_PAL, 8'd254);
    queue_item(mk_event(CMD_VBLANK, 8'hFF));
    repeat (3) queue_item(mk_event(CMD_LINE, 8'h00));
    wait_idle();

    // clearing the count rewinds the frame to the first split
    set_reg(CFG_SPLIT_COUNT, 8'd0);
    set_reg(CFG_SPLIT_COUNT, 8'd3);
    queue_item(mk_event(CMD_LINE, 8'h00));
    wait_idle();

    base   = n_offered;
    phases = 0;
    while (n_offered - base < RAND_ITEMS) begin
      no_idle = (phases % 3 == 1);
      case (phases % 5)
        1:       pick = 8'd0;
        2:       pick = 8'd255;
        default: pick = 8'($urandom);
      endcase
      set_reg(CFG_LINE_BIAS, pick);
      case ($urandom_range(0, 3))
        0:       pick = 8'd255;
        1:       pick = REG_VSCROLL;
        2:       pick = 8'd0;
        default: pick = 8'($urandom);
      endcase
      set_reg(CFG_NO_REG, pick);
      case ($urandom_range(0, 2))
        0:       pick = 8'd255;
        1:       pick = 8'd0;
        default: pick = 8'($urandom);
      endcase
      set_reg(CFG_NO_PAL, pick);
      if (phases % 4 == 0) pick = 8'd8;
      else if ($urandom_range(0, 7) == 0) pick = 8'd0;
      else pick = 8'($urandom_range(1, 15));
      set_reg(CFG_SPLIT_COUNT, pick);

      if (phases == 1) long_stall_go = 1'b1;
      repeat ($urandom_range(2, 3)) begin
        repeat ($urandom_range(0, 3)) queue_item(rand_entry());
        kind = $urandom_range(0, 7);
        if (kind == 0) begin
          // random commands of any kind, with no vblank queued in front of them
          repeat ($urandom_range(1, 4))
            queue_item(mk_event(2'($urandom), 8'($urandom)));
        end else begin
          queue_item(mk_event(CMD_VBLANK, 8'($urandom)));
          n_lines = (kind == 1) ? $urandom_range(0, m_count) : m_count + $urandom_range(0, 1);
          repeat (n_lines) begin
            if ($urandom_range(0, 9) == 0) queue_item(mk_event(CMD_IGNORED, 8'($urandom)));
            queue_item(mk_event(CMD_LINE, 8'($urandom)));
          end
        end
      end
      wait_idle();
      phases++;
    end

    $display("summary: %0d transactions (%0d vblank, %0d line), %0d port writes checked",
             n_offered, n_vblank, n_line, n_checked);
    $display("summary: %0d random register settings, %0d mismatches", phases, mismatches);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
